// File: hdl/wuf_pkg.sv
// Shared constants and controller/datapath handshake types for the
// weighted union-find engine. No dependencies.
`timescale 1ns / 1ps

package wuf_pkg;

    // Default node count and fixed field widths of the item and result words
    localparam int NODES_DEF = 256;
    localparam int NODE_IN_W = 8;
    localparam int COMP_W    = 9;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;   // write one reset entry during the clearing pass
        logic load_item;    // capture an accepted item
        logic read_p;       // start the walk from p
        logic step;         // follow the parent link just read
        logic take_rp;      // keep p's root, start the walk from q
        logic take_rq;      // keep q's root
        logic hang;         // link the smaller root under the larger one
        logic grow;         // write the merged size, drop the count
        logic emit;         // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;     // clearing pass is at its last entry
        logic at_root;      // node under walk links to itself
        logic same_root;    // node under walk equals p's root
        logic unite;        // current item is a union
        logic out_free;     // result register can take a word this cycle
    } dp_status_t;

endpackage

// File: hdl/wuf_item_if.sv
// Input channel of the union-find engine: valid/ready plus the item word.
// Depends on wuf_pkg.
`timescale 1ns / 1ps

interface wuf_item_if;

    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [wuf_pkg::NODE_IN_W-1:0]  node_p;
    logic [wuf_pkg::NODE_IN_W-1:0]  node_q;

    modport source (output valid, output cmd, output node_p, output node_q, input ready);
    modport sink   (input valid, input cmd, input node_p, input node_q, output ready);

endinterface

// File: hdl/wuf_result_if.sv
// Output channel of the union-find engine: valid/ready plus the result word.
// Depends on wuf_pkg.
`timescale 1ns / 1ps

interface wuf_result_if;

    logic                        valid;
    logic                        ready;
    logic                        already_joined;
    logic [wuf_pkg::COMP_W-1:0]  components;

    modport source (output valid, output already_joined, output components, input ready);
    modport sink   (input valid, input already_joined, input components, output ready);

endinterface

// File: hdl/wuf_datapath.sv
// Datapath of the union-find engine: node memory, walk registers,
// component count and result register. Depends on wuf_pkg.
`timescale 1ns / 1ps

module wuf_datapath #(
    parameter int NODES = wuf_pkg::NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wuf_pkg::dp_cmd_t               cmd,
    output wuf_pkg::dp_status_t            status,
    input  logic                           in_cmd,
    input  logic [wuf_pkg::NODE_IN_W-1:0]  in_node_p,
    input  logic [wuf_pkg::NODE_IN_W-1:0]  in_node_q,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_already_joined,
    output logic [wuf_pkg::COMP_W-1:0]     out_components
);

    import wuf_pkg::*;

    localparam int          IDX_W   = $clog2(NODES);
    localparam int          CNT_W   = $clog2(NODES + 1);
    localparam logic [31:0] NODES_U = 32'(NODES);

    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic [CNT_W-1:0] size;
    } entry_t;

    entry_t node_mem [NODES];

    entry_t              rd_reg;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                unite_reg;
    logic [IDX_W-1:0]    p_reg, q_reg, cur_reg, rp_reg, rq_reg;
    logic [CNT_W-1:0]    rp_size_reg, rq_size_reg;
    logic                joined_reg;
    logic                out_joined_reg;
    logic [COMP_W-1:0]   out_comp_reg;

    logic [NODE_IN_W-1:0] p_fold, q_fold;
    logic                 p_wins;
    logic [IDX_W-1:0]     big_root, small_root;
    logic [CNT_W-1:0]     small_size;
    logic [IDX_W-1:0]     mem_addr;
    logic                 mem_we;
    entry_t               mem_wdata;

    // Reduce both indexes modulo NODES by conditional subtraction of
    // NODES shifted down from 128x; nothing is subtracted once NODES >= 256.
    always_comb
    begin
        p_fold = in_node_p;
        q_fold = in_node_q;
        for (int k = NODE_IN_W - 1; k >= 0; k--)
        begin
            if (32'(p_fold) >= (NODES_U << k))
                p_fold = p_fold - NODE_IN_W'(NODES_U << k);
            if (32'(q_fold) >= (NODES_U << k))
                q_fold = q_fold - NODE_IN_W'(NODES_U << k);
        end
    end

    // Equal sizes keep p's root on top
    assign p_wins     = !(rp_size_reg < rq_size_reg);
    assign big_root   = p_wins ? rp_reg : rq_reg;
    assign small_root = p_wins ? rq_reg : rp_reg;
    assign small_size = p_wins ? rq_size_reg : rp_size_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = cur_reg;
        mem_wdata = '{link: clr_reg, size: CNT_W'(1)};
        if (cmd.clear_step)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_reg;
        end
        else if (cmd.read_p)
            mem_addr = p_reg;
        else if (cmd.step)
            mem_addr = rd_reg.link;
        else if (cmd.take_rp)
            mem_addr = q_reg;
        else if (cmd.hang)
        begin
            mem_we    = 1'b1;
            mem_addr  = small_root;
            mem_wdata = '{link: big_root, size: small_size};
        end
        else if (cmd.grow)
        begin
            mem_we    = 1'b1;
            mem_addr  = big_root;
            mem_wdata = '{link: big_root, size: rp_size_reg + rq_size_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            node_mem[mem_addr] <= mem_wdata;
        rd_reg <= node_mem[mem_addr];
    end

    always_comb
    begin
        clr_next       = clr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clear_step)
            clr_next = clr_reg + IDX_W'(1);
        if (cmd.grow && count_reg != '0)
            count_next = count_reg - CNT_W'(1);
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            count_reg     <= CNT_W'(NODES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            unite_reg <= in_cmd;
            p_reg     <= IDX_W'(p_fold);
            q_reg     <= IDX_W'(q_fold);
        end
        if (cmd.read_p)
            cur_reg <= p_reg;
        if (cmd.step)
            cur_reg <= rd_reg.link;
        if (cmd.take_rp)
        begin
            rp_reg      <= cur_reg;
            rp_size_reg <= rd_reg.size;
            cur_reg     <= q_reg;
        end
        if (cmd.take_rq)
        begin
            rq_reg      <= cur_reg;
            rq_size_reg <= rd_reg.size;
            joined_reg  <= (cur_reg == rp_reg);
        end
        if (cmd.emit)
        begin
            out_joined_reg <= joined_reg;
            out_comp_reg   <= COMP_W'(count_reg);
        end
    end

    assign status.clr_last  = (clr_reg == IDX_W'(NODES - 1));
    assign status.at_root   = (rd_reg.link == cur_reg);
    assign status.same_root = (cur_reg == rp_reg);
    assign status.unite     = unite_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid          = out_valid_reg;
    assign out_already_joined = out_joined_reg;
    assign out_components     = out_comp_reg;

endmodule

// File: hdl/wuf_controller.sv
// Sequencer of the union-find engine: clearing pass, two root walks,
// union writes and result hand-off. Depends on wuf_pkg.
`timescale 1ns / 1ps

module wuf_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wuf_pkg::dp_status_t  status,
    output wuf_pkg::dp_cmd_t     cmd
);

    import wuf_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_WALK_P = 3'd3;
    localparam logic [2:0] S_WALK_Q = 3'd4;
    localparam logic [2:0] S_HANG   = 3'd5;
    localparam logic [2:0] S_GROW   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                cmd.read_p = 1'b1;
                state_next = S_WALK_P;
            end
            S_WALK_P:
            begin
                if (status.at_root)
                begin
                    cmd.take_rp = 1'b1;
                    state_next  = S_WALK_Q;
                end
                else
                    cmd.step = 1'b1;
            end
            S_WALK_Q:
            begin
                if (status.at_root)
                begin
                    cmd.take_rq = 1'b1;
                    if (status.unite && !status.same_root)
                        state_next = S_HANG;
                    else
                        state_next = S_FINISH;
                end
                else
                    cmd.step = 1'b1;
            end
            S_HANG:
            begin
                cmd.hang   = 1'b1;
                state_next = S_GROW;
            end
            S_GROW:
            begin
                cmd.grow   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/weighted_union_find.sv
// Top level of the weighted quick-union engine: joins the controller and
// the datapath. Depends on wuf_pkg, wuf_item_if, wuf_result_if,
// wuf_controller and wuf_datapath.
`timescale 1ns / 1ps

// Channel   Dir  Word fields                         Meaning
// items     in   cmd, node_p, node_q                 query (0) or unite (1) two nodes
// results   out  already_joined, components          same root before, sets after
//
// An item walks p up to its root and then q; a union of two sets then adds
// the hang and grow writes. Weighting bounds the depth of p and of q by
// log2(NODES), so at most 8 at 256.
// Each walk step is one read of the single-port node memory.
// After reset a clearing pass writes every node as its own root before the
// first word is accepted.
// A stalled result register holds its word; the next item is taken meanwhile
// and waits only at its own hand-off.

module weighted_union_find #(
    parameter int NODES = wuf_pkg::NODES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wuf_item_if.sink      items,
    wuf_result_if.source  results
);

    import wuf_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequence the clearing pass, the two root walks and the union writes
    wuf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // Hold the node memory, walk state, set count and result register
    wuf_datapath #(
        .NODES (NODES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (dp_cmd),
        .status             (dp_status),
        .in_cmd             (items.cmd),
        .in_node_p          (items.node_p),
        .in_node_q          (items.node_q),
        .out_valid          (results.valid),
        .out_ready          (results.ready),
        .out_already_joined (results.already_joined),
        .out_components     (results.components)
    );

endmodule

// File: verif/weighted_union_find_tb.sv
// Self-checking testbench for the weighted quick-union engine: it drives item words,
// predicts every result word with a software union-find, and checks each field.
// Depends on wuf_pkg, wuf_item_if, wuf_result_if and weighted_union_find.
`timescale 1ns / 1ps

module weighted_union_find_tb;

    import wuf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int NODE_COUNT   = NODES_DEF;
    localparam int IDLE_PCT     = 29;       // chance in 100 that a side idles in a cycle
    localparam int HOLD_CYCLES  = 400;      // length of the long receiver hold-off
    localparam int DRAIN_CYCLES = 40;       // quiet time after the last expected word
    localparam int LIMIT_CYCLES = 400_000;  // watchdog, several times the slowest run

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_UNITE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [NODE_IN_W-1:0] node_p;
        logic [NODE_IN_W-1:0] node_q;
    } item_word_t;

    typedef struct packed {
        logic              joined;
        logic [COMP_W-1:0] components;
    } result_word_t;

    logic clk = 1'b0;
    logic rst_n;

    wuf_item_if   items_ch ();
    wuf_result_if results_ch ();

    weighted_union_find i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Words waiting to be offered, and result words predicted but not yet seen
    item_word_t   pending_items[$];
    result_word_t expected_results[$];

    int  words_taken = 0;
    int  mismatches  = 0;
    logic hold_off;

    // Neither side idles while this window of accepted words is open
    wire calm = (words_taken >= 500) && (words_taken < 800);

    // -------------------------------------------------------------------------
    // Disjoint-set shadow: parent links, tree weights (valid at roots only)
    // and the number of sets. Updated once per accepted item word.
    // -------------------------------------------------------------------------
    int parent_of [NODE_COUNT];
    int tree_weight[NODE_COUNT];
    int set_total;

    // Follow parent links up to the root; the step bound is never hit by
    // weighted trees but keeps a corrupt shadow from hanging the run.
    function automatic int root_of(int node);
        int steps;
        steps = 0;
        while (parent_of[node] != node && steps < NODE_COUNT)
        begin
            node = parent_of[node];
            steps++;
        end
        return node;
    endfunction

    // Apply one item word to the shadow and return the result word it causes
    function automatic result_word_t join_sets(item_word_t w);
        int rp;
        int rq;
        result_word_t r;
        rp = root_of(int'(w.node_p) % NODE_COUNT);
        rq = root_of(int'(w.node_q) % NODE_COUNT);
        if (w.cmd == CMD_UNITE && rp != rq)
        begin
            // Hang the lighter root under the heavier one; on a tie q's root goes under p's
            if (tree_weight[rp] < tree_weight[rq])
            begin
                parent_of[rp]    = rq;
                tree_weight[rq] += tree_weight[rp];
            end
            else
            begin
                parent_of[rq]    = rp;
                tree_weight[rp] += tree_weight[rq];
            end
            if (set_total > 0)
                set_total--;
        end
        r.joined     = (rp == rq);
        r.components = set_total[COMP_W-1:0];
        return r;
    endfunction

    task automatic add_item(logic cmd, int p, int q);
        item_word_t w;
        w.cmd    = cmd;
        w.node_p = p[NODE_IN_W-1:0];
        w.node_q = q[NODE_IN_W-1:0];
        pending_items.push_back(w);
    endtask

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // -------------------------------------------------------------------------
    // Driver: offer the next pending word, hold it until accepted, and idle
    // at random between words. Predict each word at the edge that takes it.
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_ch.valid  <= 1'b0;
            items_ch.cmd    <= CMD_QUERY;
            items_ch.node_p <= '0;
            items_ch.node_q <= '0;
        end
        else
        begin
            item_word_t nxt;
            if (items_ch.valid && items_ch.ready)
            begin
                nxt.cmd    = items_ch.cmd;
                nxt.node_p = items_ch.node_p;
                nxt.node_q = items_ch.node_q;
                expected_results.push_back(join_sets(nxt));
                words_taken <= words_taken + 1;
            end
            // Advance only when nothing is held or the held word just went through
            if (!items_ch.valid || items_ch.ready)
            begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_items.pop_front();
                    items_ch.valid  <= 1'b1;
                    items_ch.cmd    <= nxt.cmd;
                    items_ch.node_p <= nxt.node_p;
                    items_ch.node_q <= nxt.node_q;
                end
                else
                begin
                    items_ch.valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Monitor: check every accepted result word against the oldest prediction,
    // and stall at random or for the whole hold-off.
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
        end
        else
        begin
            result_word_t want;
            if (results_ch.valid && results_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result word arrived with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (results_ch.already_joined !== want.joined)
                        report_mismatch($sformatf("already_joined %b, expected %b",
                                                  results_ch.already_joined, want.joined));
                    if (results_ch.components !== want.components)
                        report_mismatch($sformatf("components %0d, expected %0d",
                                                  results_ch.components, want.components));
                end
            end
            results_ch.ready <= !hold_off && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long receiver hold-off: the driver keeps offering, so the result register
    // fills, the next item parks at its hand-off and the input stalls.
    initial
    begin
        hold_off = 1'b0;
        wait (words_taken >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Stimulus and end of run
    // -------------------------------------------------------------------------
    initial
    begin
        int k;
        int p;

        rst_n = 1'b0;

        // Shadow starts where the block does after reset: every node its own root
        for (k = 0; k < NODE_COUNT; k++)
        begin
            parent_of[k]   = k;
            tree_weight[k] = 1;
        end
        set_total = NODE_COUNT;

        // Directed: same node twice, end nodes, ties, lighter root on either side,
        // union of joined nodes, alternating bit patterns, a balanced deeper tree.
        add_item(CMD_QUERY, 0, 0);
        add_item(CMD_UNITE, 0, 0);
        add_item(CMD_QUERY, 0, 255);
        add_item(CMD_UNITE, 0, 255);     // tie: q's root under p's
        add_item(CMD_UNITE, 255, 0);     // already joined, nothing changes
        add_item(CMD_QUERY, 255, 0);
        add_item(CMD_UNITE, 1, 2);
        add_item(CMD_UNITE, 3, 1);       // p's root is lighter
        add_item(CMD_UNITE, 0, 3);       // p's root is lighter again, other order
        add_item(CMD_UNITE, 170, 85);
        add_item(CMD_UNITE, 85, 255);
        add_item(CMD_QUERY, 2, 170);
        add_item(CMD_QUERY, 127, 128);
        // Build a depth-3 tree on nodes 32..39 by pairing, then pairs of pairs
        for (k = 32; k < 40; k += 2)
            add_item(CMD_UNITE, k, k + 1);
        add_item(CMD_UNITE, 32, 34);
        add_item(CMD_UNITE, 36, 38);
        add_item(CMD_UNITE, 39, 33);
        add_item(CMD_QUERY, 39, 35);
        add_item(CMD_UNITE, 39, 255);    // deep node into the big tree

        // Random: mostly queries with plenty of unions, so the count falls
        // through its whole range and trees grow several levels deep.
        for (k = 0; k < 1150; k++)
        begin
            p = $urandom_range(NODE_COUNT - 1);
            add_item(($urandom_range(99) < 40) ? CMD_UNITE : CMD_QUERY, p,
                     ($urandom_range(9) == 0) ? p : $urandom_range(NODE_COUNT - 1));
        end

        // Sweep neighbors together so the count ends at one set
        for (k = 0; k < NODE_COUNT - 1; k++)
        begin
            add_item(CMD_UNITE, k, k + 1);
            if (k % 8 == 0)
                add_item(CMD_QUERY, $urandom_range(NODE_COUNT - 1),
                         $urandom_range(NODE_COUNT - 1));
        end
        add_item(CMD_QUERY, 0, 255);
        add_item(CMD_UNITE, 200, 17);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every word offered and taken, every result seen, then stay
        // quiet a while so a stray extra result word gets caught.
        while (pending_items.size() > 0 || items_ch.valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
